FILE: rtl/core/vnu_pkg.sv
// ----------------------------------------------------------------------------
// vnu_pkg
// Widths, constants and word types shared by the vector normalize unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vnu_pkg;

  localparam int COMPONENT_BITS       = 16;
  localparam int RESULT_FRACTION_BITS = 14;
  localparam int LANES                = 4;

  localparam int UNIT_BITS = RESULT_FRACTION_BITS + 2;
  localparam int SQ_BITS   = 2 * COMPONENT_BITS;
  localparam int SUM_BITS  = 2 * COMPONENT_BITS + 2;
  localparam int ROOT_BITS = COMPONENT_BITS + 1;
  localparam int REM_BITS  = ROOT_BITS + 3;
  localparam int QUOT_BITS = RESULT_FRACTION_BITS + 1;
  localparam int NUM_BITS  = COMPONENT_BITS + RESULT_FRACTION_BITS + 1;
  localparam int TAG_BITS  = LANES * (COMPONENT_BITS + 1);

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] comp_x;
    logic signed [COMPONENT_BITS-1:0] comp_y;
    logic signed [COMPONENT_BITS-1:0] comp_z;
    logic signed [COMPONENT_BITS-1:0] comp_w;
  } vec_word_t;

  typedef struct packed {
    logic signed [UNIT_BITS-1:0] unit_x;
    logic signed [UNIT_BITS-1:0] unit_y;
    logic signed [UNIT_BITS-1:0] unit_z;
    logic signed [UNIT_BITS-1:0] unit_w;
    logic                        zero_error;
  } unit_word_t;

  typedef struct packed {
    logic [QUOT_BITS-1:0] quot;
    logic                 neg;
    logic                 len_zero;
  } lane_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/vnu_square_lane.sv
// ----------------------------------------------------------------------------
// vnu_square_lane
// Takes the magnitude and sign of one component and squares it, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vnu_square_lane
  import vnu_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      adv,
  input  wire logic [COMPONENT_BITS-1:0] comp,
  output logic      [COMPONENT_BITS-1:0] mag,
  output logic                           neg,
  output logic      [SQ_BITS-1:0]        sq
);

  logic                      neg_c;
  logic [COMPONENT_BITS-1:0] mag_c;
  logic [SQ_BITS-1:0]        mag_ext;

  assign neg_c   = comp[COMPONENT_BITS-1];
  assign mag_c   = neg_c ? (~comp + 1'b1) : comp;
  assign mag_ext = {{COMPONENT_BITS{1'b0}}, mag_c};

  always_ff @(posedge clk) begin
    if (adv) begin
      mag <= mag_c;
      neg <= neg_c;
      sq  <= mag_ext * mag_ext;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vnu_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// vnu_sqrt_pipe
// Pipelined integer square root, rounded down, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vnu_sqrt_pipe
  import vnu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 adv,
  input  wire logic [SUM_BITS-1:0]  rad,
  input  wire logic [TAG_BITS-1:0]  tag_in,
  output logic      [ROOT_BITS-1:0] root,
  output logic      [TAG_BITS-1:0]  tag_out
);

  logic [REM_BITS-1:0]  rem_q  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_q [ROOT_BITS];
  logic [SUM_BITS-1:0]  rad_q  [ROOT_BITS];
  logic [TAG_BITS-1:0]  tag_q  [ROOT_BITS];

  for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
    logic [REM_BITS-1:0]  rem_in;
    logic [ROOT_BITS-1:0] root_in;
    logic [SUM_BITS-1:0]  rad_in;
    logic [TAG_BITS-1:0]  tag_s;
    logic [REM_BITS-1:0]  rem_sh;
    logic [REM_BITS-1:0]  trial;
    logic                 take;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
      assign tag_s   = tag_in;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign tag_s   = tag_q[s-1];
    end

    assign rem_sh = {rem_in[REM_BITS-3:0], rad_in[SUM_BITS-1:SUM_BITS-2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[s]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[s] <= {root_in[ROOT_BITS-2:0], take};
        rad_q[s]  <= {rad_in[SUM_BITS-3:0], 2'b00};
        tag_q[s]  <= tag_s;
      end
    end
  end

  assign root    = root_q[ROOT_BITS-1];
  assign tag_out = tag_q[ROOT_BITS-1];

endmodule

`default_nettype wire

FILE: rtl/core/vnu_div_lane.sv
// ----------------------------------------------------------------------------
// vnu_div_lane
// Pipelined restoring divider: rounded magnitude over length, one bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vnu_div_lane
  import vnu_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      adv,
  input  wire logic [COMPONENT_BITS-1:0] mag,
  input  wire logic                      neg,
  input  wire logic [ROOT_BITS-1:0]      len,
  output lane_result_t                   res
);

  logic [NUM_BITS-1:0]  rem_q  [QUOT_BITS];
  logic [QUOT_BITS-1:0] quot_q [QUOT_BITS];
  logic [ROOT_BITS-1:0] len_q  [QUOT_BITS];
  logic                 neg_q  [QUOT_BITS];

  logic [NUM_BITS-1:0] num;

  // rounding: add half the length before dividing
  assign num = {1'b0, mag, {RESULT_FRACTION_BITS{1'b0}}}
             + NUM_BITS'(len >> 1);

  for (genvar s = 0; s < QUOT_BITS; s++) begin : g_stage
    logic [NUM_BITS-1:0]  rem_in;
    logic [QUOT_BITS-1:0] quot_in;
    logic [ROOT_BITS-1:0] len_in;
    logic                 neg_in;
    logic [NUM_BITS-1:0]  dvs;
    logic                 take;

    if (s == 0) begin : g_first
      assign rem_in  = num;
      assign quot_in = '0;
      assign len_in  = len;
      assign neg_in  = neg;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
      assign len_in  = len_q[s-1];
      assign neg_in  = neg_q[s-1];
    end

    assign dvs  = NUM_BITS'(len_in) << (QUOT_BITS - 1 - s);
    assign take = rem_in >= dvs;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[s]  <= take ? (rem_in - dvs) : rem_in;
        quot_q[s] <= {quot_in[QUOT_BITS-2:0], take};
        len_q[s]  <= len_in;
        neg_q[s]  <= neg_in;
      end
    end
  end

  assign res.quot     = quot_q[QUOT_BITS-1];
  assign res.neg      = neg_q[QUOT_BITS-1];
  assign res.len_zero = (len_q[QUOT_BITS-1] == '0);

endmodule

`default_nettype wire

FILE: rtl/core/vec4_normalize_unit.sv
// ----------------------------------------------------------------------------
// vec4_normalize_unit
// Normalizes a four-component Q3.12 vector to a Q1.14 unit vector.
// ----------------------------------------------------------------------------
// Fully pipelined: one vector word is accepted every cycle unless the output
// stalls, and its unit word passes through the squaring registers, the sum
// register, the square root pipeline (one root bit a stage), the four lane
// dividers (one quotient bit a stage) and the output register. A zero vector
// gives zero components with zero_error set. The whole pipeline holds when
// the output word is not taken.
`default_nettype none

module vec4_normalize_unit
  import vnu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       vec_valid,
  output logic            vec_ready,
  input  wire vec_word_t  vec,
  output logic            unit_valid,
  input  wire logic       unit_ready,
  output unit_word_t      unit
);

  localparam int LAT = ROOT_BITS + QUOT_BITS + 3;

  logic [LAT-1:0] vld;
  logic           adv;

  logic [COMPONENT_BITS-1:0] comp [LANES];
  logic [COMPONENT_BITS-1:0] mag1 [LANES];
  logic                      neg1 [LANES];
  logic [SQ_BITS-1:0]        sq1  [LANES];

  logic [SUM_BITS-1:0]       sum2;
  logic [TAG_BITS-1:0]       tag2;
  logic [TAG_BITS-1:0]       tag3;
  logic [ROOT_BITS-1:0]      len3;
  lane_result_t              res  [LANES];
  logic [UNIT_BITS-1:0]      uval [LANES];

  assign adv        = ~vld[LAT-1] | unit_ready;
  assign vec_ready  = adv;
  assign unit_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], vec_valid};
    end
  end

  assign comp[0] = vec.comp_x;
  assign comp[1] = vec.comp_y;
  assign comp[2] = vec.comp_z;
  assign comp[3] = vec.comp_w;

  for (genvar i = 0; i < LANES; i++) begin : g_sq
    vnu_square_lane u_sq (
      .clk  (clk),
      .adv  (adv),
      .comp (comp[i]),
      .mag  (mag1[i]),
      .neg  (neg1[i]),
      .sq   (sq1[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum2 <= SUM_BITS'(sq1[0]) + SUM_BITS'(sq1[1])
            + SUM_BITS'(sq1[2]) + SUM_BITS'(sq1[3]);
      tag2 <= {neg1[3], mag1[3], neg1[2], mag1[2],
               neg1[1], mag1[1], neg1[0], mag1[0]};
    end
  end

  vnu_sqrt_pipe u_sqrt (
    .clk     (clk),
    .adv     (adv),
    .rad     (sum2),
    .tag_in  (tag2),
    .root    (len3),
    .tag_out (tag3)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_div
    localparam int LO = i * (COMPONENT_BITS + 1);

    vnu_div_lane u_div (
      .clk (clk),
      .adv (adv),
      .mag (tag3[LO +: COMPONENT_BITS]),
      .neg (tag3[LO + COMPONENT_BITS]),
      .len (len3),
      .res (res[i])
    );

    assign uval[i] = res[i].len_zero ? '0
                   : res[i].neg ? (~UNIT_BITS'(res[i].quot) + 1'b1)
                   : UNIT_BITS'(res[i].quot);
  end

  // merge the lanes into the output word
  always_ff @(posedge clk) begin
    if (adv) begin
      unit.unit_x     <= uval[0];
      unit.unit_y     <= uval[1];
      unit.unit_z     <= uval[2];
      unit.unit_w     <= uval[3];
      unit.zero_error <= res[0].len_zero;
    end
  end

endmodule

`default_nettype wire
